[sv/aast_pkg.sv]
// ----------------------------------------------------------------------------
// aast_pkg: shared types and constants for the angle step tracker
// Direction codes, configuration register indexes, reset values and the
// state and configuration records passed between the tracker modules.
// ----------------------------------------------------------------------------
package aast_pkg;

  localparam int AngleW    = 12;
  localparam int CountW    = 16;
  localparam int ThrW      = 8;
  localparam int BalanceW  = 9;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  // Wrap limits for the angle delta (half a turn and one turn)
  localparam logic signed [AngleW+1:0] HalfTurn = 14'sd2048;
  localparam logic signed [AngleW+1:0] FullTurn = 14'sd4096;

  // Reset values of the configuration registers
  localparam logic [AngleW-1:0] DeadzoneReset     = 12'd42;
  localparam logic [ThrW-1:0]   ThresholdReset    = 8'd2;
  localparam logic [CountW-1:0] HoldTicksReset    = 16'd100;
  localparam logic [CountW-1:0] LogicalStepReset  = 16'd1;
  localparam logic [CountW-1:0] StepsPerTurnReset = 16'd24;
  localparam logic [AngleW-1:0] StartAngleReset   = 12'd0;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_DEADZONE       = 3'd0,
    CFG_THRESHOLD      = 3'd1,
    CFG_HOLD_TICKS     = 3'd2,
    CFG_LOGICAL_STEP   = 3'd3,
    CFG_STEPS_PER_TURN = 3'd4,
    CFG_START_ANGLE    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [AngleW-1:0] deadzone;
    logic [ThrW-1:0]   threshold;
    logic [CountW-1:0] hold_ticks;
    logic [CountW-1:0] logical_step;
    logic [CountW-1:0] steps_per_turn;
  } track_cfg_t;

  typedef struct packed {
    logic [AngleW-1:0]          last_angle;
    logic [CountW-1:0]          logical_count;
    logic [CountW-1:0]          physical_count;
    logic signed [BalanceW-1:0] balance;
    dir_t                       dir;
    logic [CountW-1:0]          hold_timer;
  } track_state_t;

endpackage

[sv/aast_step.sv]
// ----------------------------------------------------------------------------
// aast_step: next-state logic for one angle sample
// Runs the hold timer, wraps the angle delta, applies the deadzone and
// advances logical position, physical index and direction balance.
// ----------------------------------------------------------------------------
module aast_step (
  input  aast_pkg::track_cfg_t             cfg,
  input  aast_pkg::track_state_t           cur,
  input  logic [aast_pkg::AngleW-1:0]      angle,
  input  logic                             sample_ok,
  output aast_pkg::track_state_t           nxt,
  output logic                             moved
);
  import aast_pkg::*;

  logic signed [AngleW+1:0]   diff;
  logic signed [AngleW+1:0]   delta;
  logic signed [AngleW+1:0]   mag_full;
  logic [AngleW-1:0]          mag;
  logic                       neg;
  logic signed [BalanceW-1:0] bal_up;
  logic signed [BalanceW-1:0] bal_dn;
  logic signed [BalanceW:0]   thr_s;
  logic                       latch_up;
  logic                       latch_dn;
  logic [CountW-1:0]          phys_up;
  logic [CountW-1:0]          phys_dn;
  logic [CountW-1:0]          hold_run;
  dir_t                       dir_run;

  // Count down the hold timer, drop the direction once it has run out
  always_comb begin
    if (cur.hold_timer != '0) begin
      hold_run = cur.hold_timer - 1'b1;
      dir_run  = cur.dir;
    end else begin
      hold_run = cur.hold_timer;
      dir_run  = DIR_NONE;
    end
  end

  // Wrap the delta into half a turn either way and take its magnitude
  always_comb begin
    diff = $signed({2'b00, angle}) - $signed({2'b00, cur.last_angle});
    if (diff > HalfTurn) begin
      delta = diff - FullTurn;
    end else if (diff < -HalfTurn) begin
      delta = diff + FullTurn;
    end else begin
      delta = diff;
    end
    neg      = delta[AngleW+1];
    mag_full = neg ? -delta : delta;
    mag      = mag_full[AngleW-1:0];
  end

  assign moved = sample_ok && (mag >= cfg.deadzone);

  // Balance moves one step; latch when it reaches the threshold
  assign bal_up   = cur.balance + 9'sd1;
  assign bal_dn   = cur.balance - 9'sd1;
  assign thr_s    = $signed({2'b00, cfg.threshold});
  assign latch_up = $signed({bal_up[BalanceW-1], bal_up}) >= thr_s;
  assign latch_dn = $signed({bal_dn[BalanceW-1], bal_dn}) <= -thr_s;

  // Physical index wraps over one turn
  always_comb begin
    phys_up = cur.physical_count + 1'b1;
    if (phys_up >= cfg.steps_per_turn) begin
      phys_up = '0;
    end
    phys_dn = cur.physical_count - 1'b1;
    if (phys_dn >= cfg.steps_per_turn) begin
      phys_dn = cfg.steps_per_turn - 1'b1;
    end
  end

  // Assemble the next state
  always_comb begin
    nxt            = cur;
    nxt.hold_timer = hold_run;
    nxt.dir        = dir_run;
    if (moved) begin
      nxt.last_angle = angle;
      if (neg) begin
        nxt.logical_count  = cur.logical_count - cfg.logical_step;
        nxt.physical_count = phys_dn;
        if (latch_dn) begin
          nxt.balance    = '0;
          nxt.dir        = DIR_CCW;
          nxt.hold_timer = cfg.hold_ticks;
        end else begin
          nxt.balance = bal_dn;
        end
      end else begin
        nxt.logical_count  = cur.logical_count + cfg.logical_step;
        nxt.physical_count = phys_up;
        if (latch_up) begin
          nxt.balance    = '0;
          nxt.dir        = DIR_CW;
          nxt.hold_timer = cfg.hold_ticks;
        end else begin
          nxt.balance = bal_up;
        end
      end
    end
  end

endmodule

[sv/absolute_angle_to_step_tracker.sv]
// ----------------------------------------------------------------------------
// absolute_angle_to_step_tracker: absolute angle samples to step counts
// Turns 12-bit absolute angle samples into logical position, physical step
// index and a held direction report, one result per sample.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_axis   in   s_tvalid/s_tready  s_tdata angle, s_tuser sample_ok
// m_axis   out  m_tvalid/m_tready  m_tdata direction, index, position, moved
// cfg      in   cfg_valid/ready    cfg_index, cfg_data
//
// One sample per cycle sustained while m_tready stays high; each sample passes
// through the input register, then the result register.
// The tracker state updates in the cycle the sample moves into the result
// register, so consecutive samples see each other's updates directly.
// A stalled m_tready holds the result register and then the input register.
// rst (synchronous) restores config, tracker state and valid flags to defaults.
// ----------------------------------------------------------------------------
module absolute_angle_to_step_tracker (
  input  logic                               clk,
  input  logic                               rst,
  // sample request
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,  // [11:0] angle, [15:12] zero
  input  logic [0:0]                         s_tuser,  // [0] sample_ok
  // result
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [39:0]                        m_tdata,  // [1:0] direction,
                                                       // [17:2] physical_index,
                                                       // [33:18] logical_position,
                                                       // [34] moved, [39:35] zero
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aast_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [aast_pkg::CfgDataW-1:0]      cfg_data
);
  import aast_pkg::*;

  track_cfg_t          cfg;
  track_state_t        st;
  track_state_t        st_next;
  logic                step_moved;

  logic                in_valid;
  logic [AngleW-1:0]   in_angle;
  logic                in_ok;
  logic                fire;
  logic                cfg_we;

  logic [1:0]          out_dir;
  logic [CountW-1:0]   out_phys;
  logic [CountW-1:0]   out_logical;
  logic                out_moved;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;

  aast_step u_step (
    .cfg       (cfg),
    .cur       (st),
    .angle     (in_angle),
    .sample_ok (in_ok),
    .nxt       (st_next),
    .moved     (step_moved)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone       <= DeadzoneReset;
      cfg.threshold      <= ThresholdReset;
      cfg.hold_ticks     <= HoldTicksReset;
      cfg.logical_step   <= LogicalStepReset;
      cfg.steps_per_turn <= StepsPerTurnReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEADZONE:       cfg.deadzone       <= cfg_data[AngleW-1:0];
        CFG_THRESHOLD:      cfg.threshold      <= cfg_data[ThrW-1:0];
        CFG_HOLD_TICKS:     cfg.hold_ticks     <= cfg_data;
        CFG_LOGICAL_STEP:   cfg.logical_step   <= cfg_data;
        CFG_STEPS_PER_TURN: cfg.steps_per_turn <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tracker state; a start angle write also reloads the reference angle
  always_ff @(posedge clk) begin
    if (rst) begin
      st.last_angle     <= StartAngleReset;
      st.logical_count  <= '0;
      st.physical_count <= '0;
      st.balance        <= '0;
      st.dir            <= DIR_NONE;
      st.hold_timer     <= '0;
    end else if (cfg_we && (cfg_index == CFG_START_ANGLE)) begin
      st.last_angle <= cfg_data[AngleW-1:0];
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Input register: take a request whenever the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_angle <= s_tdata[AngleW-1:0];
      in_ok    <= s_tuser[0];
    end
  end

  // Result register: load on fire, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_dir     <= st_next.dir;
      out_phys    <= st_next.physical_count;
      out_logical <= st_next.logical_count;
      out_moved   <= step_moved;
    end
  end

  assign m_tdata = {5'b0, out_moved, out_logical, out_phys, out_dir};

  // A full input register only ever waits on a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a stalled result");

  // A sample without a step leaves the logical position alone
  a_no_step_hold: assert property (@(posedge clk) disable iff (rst)
    (fire && !step_moved && !cfg_we) |=> $stable(st.logical_count))
    else $error("logical position moved without a step");

  // An expired timer with no step reports no direction
  a_dir_expire: assert property (@(posedge clk) disable iff (rst)
    (fire && !step_moved && (st.hold_timer == '0)) |=> (st.dir == DIR_NONE))
    else $error("direction held past its timer");

  // Direction never takes the unused code
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_dir != 2'd3))
    else $error("unused direction code on the result");

endmodule

[tb/absolute_angle_to_step_tracker_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// absolute_angle_to_step_tracker_tb: self-checking bench for the step tracker
// Drives angle samples through the stream input and predicts every result
// with a behavioral copy of the tracker state. Covers wrap and deadzone
// corners, register corners, random rotation walks under random idling on
// both sides, and a long output stall that backs the block up.
// ----------------------------------------------------------------------------
module absolute_angle_to_step_tracker_tb;
  import aast_pkg::*;

  typedef struct {
    dir_t              dir;
    logic [CountW-1:0] index;
    logic [CountW-1:0] position;
    logic              moved;
  } track_result_t;

  // Register index that the block must ignore
  localparam logic [CfgIndexW-1:0] CfgUnused = 3'd7;
  localparam int MaxReports = 40;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic [0:0]           s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [39:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  // Predicted register contents
  logic [AngleW-1:0] zone_width = DeadzoneReset;
  logic [ThrW-1:0]   latch_steps = ThresholdReset;
  logic [CountW-1:0] hold_len   = HoldTicksReset;
  logic [CountW-1:0] pos_step   = LogicalStepReset;
  logic [CountW-1:0] turn_steps = StepsPerTurnReset;

  // Predicted tracker state
  logic [AngleW-1:0]          anchor_angle = StartAngleReset;
  logic [CountW-1:0]          position     = '0;
  logic [CountW-1:0]          step_index   = '0;
  logic signed [BalanceW-1:0] net_steps    = '0;
  dir_t                       shown_dir    = DIR_NONE;
  logic [CountW-1:0]          hold_left    = '0;

  track_result_t pending_results[$];

  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int stall_request = 0;
  int stall_left    = 0;
  int walk_angle    = 0;
  int walk_way      = 1;

  int error_count   = 0;
  int sample_count  = 0;
  int failed_count  = 0;
  int result_count  = 0;
  int step_count    = 0;
  int setting_count = 0;

  absolute_angle_to_step_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Advance the predicted state by one poll tick and return its result
  function automatic track_result_t track_sample(input logic [AngleW-1:0] angle,
                                                 input logic ok);
    track_result_t     r;
    int                delta;
    int                span;
    logic [CountW-1:0] idx;
    r.moved = 1'b0;
    if (hold_left != '0) begin
      hold_left = hold_left - 1'b1;
    end else begin
      shown_dir = DIR_NONE;
    end
    if (ok) begin
      delta = int'(angle) - int'(anchor_angle);
      if (delta > HalfTurn) begin
        delta -= FullTurn;
      end else if (delta < -HalfTurn) begin
        delta += FullTurn;
      end
      span = (delta < 0) ? -delta : delta;
      if (span >= int'(zone_width)) begin
        r.moved = 1'b1;
        if (delta < 0) begin
          position  = position - pos_step;
          net_steps = net_steps - 9'sd1;
          if (int'(net_steps) <= -int'(latch_steps)) begin
            net_steps = '0;
            shown_dir = DIR_CCW;
            hold_left = hold_len;
          end
          idx = step_index - 1'b1;
          if (idx >= turn_steps) idx = turn_steps - 1'b1;
        end else begin
          position  = position + pos_step;
          net_steps = net_steps + 9'sd1;
          if (int'(net_steps) >= int'(latch_steps)) begin
            net_steps = '0;
            shown_dir = DIR_CW;
            hold_left = hold_len;
          end
          idx = step_index + 1'b1;
          if (idx >= turn_steps) idx = '0;
        end
        step_index   = idx;
        anchor_angle = angle;
      end
    end
    r.dir      = shown_dir;
    r.index    = step_index;
    r.position = position;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    error_count++;
    if (error_count <= MaxReports)
      $display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  // Offer one sample; record its prediction once the block takes the request
  task automatic send_sample(input logic [AngleW-1:0] angle, input logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(16 - AngleW){1'b0}}, angle};
    s_tuser  <= ok;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(track_sample(angle, ok));
    sample_count++;
    if (!ok) failed_count++;
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_register(input logic [CfgIndexW-1:0] idx,
                                input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEADZONE:       zone_width  = value[AngleW-1:0];
      CFG_THRESHOLD:      latch_steps = value[ThrW-1:0];
      CFG_HOLD_TICKS:     hold_len    = value;
      CFG_LOGICAL_STEP:   pos_step    = value;
      CFG_STEPS_PER_TURN: turn_steps  = value;
      CFG_START_ANGLE:    anchor_angle = value[AngleW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drain all outstanding results and leave the pipeline idle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Pick a fresh register setting, corners included
  task automatic shuffle_config();
    logic [CfgDataW-1:0] word;
    wait_idle();
    word = 16'($urandom);
    case ($urandom_range(5))
      0:       word[AngleW-1:0] = '0;
      1:       word[AngleW-1:0] = 12'($urandom_range(16, 1));
      2:       word[AngleW-1:0] = 12'($urandom_range(200, 17));
      3:       word[AngleW-1:0] = 12'($urandom_range(2048));
      4:       word[AngleW-1:0] = 12'd2048;
      default: word[AngleW-1:0] = 12'($urandom_range(4095, 2049));
    endcase
    write_register(CFG_DEADZONE, word);
    word = 16'($urandom);
    case ($urandom_range(4))
      0:       word[ThrW-1:0] = '0;
      1:       word[ThrW-1:0] = 8'd1;
      2:       word[ThrW-1:0] = 8'($urandom_range(8, 2));
      3:       word[ThrW-1:0] = 8'hFF;
      default: ;
    endcase
    write_register(CFG_THRESHOLD, word);
    case ($urandom_range(4))
      0:       word = '0;
      1:       word = 16'($urandom_range(5, 1));
      2:       word = 16'($urandom_range(60, 6));
      3:       word = 16'hFFFF;
      default: word = 16'($urandom);
    endcase
    write_register(CFG_HOLD_TICKS, word);
    case ($urandom_range(3))
      0:       word = '0;
      1:       word = 16'd1;
      2:       word = 16'hFFFF;
      default: word = 16'($urandom);
    endcase
    write_register(CFG_LOGICAL_STEP, word);
    case ($urandom_range(5))
      0:       word = '0;
      1:       word = 16'd1;
      2:       word = 16'd2;
      3:       word = 16'($urandom_range(30, 3));
      4:       word = 16'hFFFF;
      default: word = 16'($urandom);
    endcase
    write_register(CFG_STEPS_PER_TURN, word);
    if ($urandom_range(1) != 0) write_register(CFG_START_ANGLE, 16'($urandom));
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  // Mostly rotation walks that clear the deadzone, with jitter, jumps and bad reads
  task automatic run_traffic(input int count);
    int roll;
    int stride;
    int reach;
    for (int k = 0; k < count; k++) begin
      roll  = $urandom_range(99);
      reach = (int'(zone_width) > 2048) ? 2048 : int'(zone_width);
      if (roll < 8) begin
        send_sample(12'($urandom), 1'b0);
      end else if (roll < 14) begin
        walk_angle = $urandom_range(4095);
        send_sample(12'(walk_angle), 1'b1);
      end else begin
        if (roll < 22) begin
          stride = $urandom_range(reach);
          if ($urandom_range(1) != 0) stride = -stride;
        end else begin
          if ($urandom_range(99) < 15) walk_way = -walk_way;
          stride = reach + $urandom_range(48);
          if (stride > 2048) stride = 2048;
          stride = walk_way * stride;
        end
        walk_angle = (walk_angle + stride) & 32'hFFF;
        send_sample(12'(walk_angle), 1'b1);
      end
    end
  endtask

  // Default registers: deadzone edges, half-turn wrap both ways, step down from zero
  task automatic test_basic_steps();
    send_sample(12'd0, 1'b1);
    send_sample(12'd41, 1'b1);
    send_sample(12'd42, 1'b1);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'd84, 1'b1);
    send_sample(12'hFFF, 1'b1);
    send_sample(12'd2047, 1'b1);
    send_sample(12'hFFF, 1'b1);
    send_sample(12'd0, 1'b1);
    send_sample(12'd2049, 1'b1);
    send_sample(12'd1, 1'b1);
    send_sample(12'd2050, 1'b1);
  endtask

  // Register corners: zero and oversized deadzone, zero threshold and hold,
  // zero and full steps_per_turn, an index left beyond a shrunk turn
  task automatic test_register_corners();
    wait_idle();
    write_register(CFG_DEADZONE, 16'hF000);
    write_register(CFG_START_ANGLE, 16'h0800);
    write_register(CfgUnused, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_sample(12'h800, 1'b1);
    wait_idle();
    write_register(CFG_DEADZONE, 16'd2049);
    cfg_valid <= 1'b0;
    send_sample(12'h000, 1'b1);
    send_sample(12'hFFF, 1'b1);
    wait_idle();
    write_register(CFG_DEADZONE, 16'd1);
    write_register(CFG_THRESHOLD, 16'd0);
    write_register(CFG_HOLD_TICKS, 16'd0);
    write_register(CFG_LOGICAL_STEP, 16'hFFFF);
    write_register(CFG_STEPS_PER_TURN, 16'd0);
    cfg_valid <= 1'b0;
    send_sample(12'h7F0, 1'b1);
    send_sample(12'h7F0, 1'b0);
    send_sample(12'h800, 1'b1);
    wait_idle();
    write_register(CFG_STEPS_PER_TURN, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_sample(12'h7F0, 1'b1);
    wait_idle();
    write_register(CFG_STEPS_PER_TURN, 16'd24);
    write_register(CFG_THRESHOLD, 16'hFFFF);
    write_register(CFG_HOLD_TICKS, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_sample(12'h7E0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int send_pct, input int take_pct);
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    for (int p = 0; p < 5; p++) begin
      shuffle_config();
      run_traffic(60);
    end
    wait_idle();
  endtask

  // Hold the output off long enough that the block backs up into its input
  task automatic test_output_stall();
    send_idle_pct = 0;
    take_idle_pct = 0;
    shuffle_config();
    stall_request = 150;
    @(negedge clk);
    run_traffic(30);
    wait_idle();
  endtask

  // Receiver: random holds plus a requested long stall
  always @(negedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    track_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (m_tdata[34]) step_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] != want.dir)
          report_mismatch("direction", m_tdata[1:0], want.dir);
        if (m_tdata[17:2] != want.index)
          report_mismatch("physical_index", m_tdata[17:2], want.index);
        if (m_tdata[33:18] != want.position)
          report_mismatch("logical_position", m_tdata[33:18], want.position);
        if (m_tdata[34] != want.moved)
          report_mismatch("moved", m_tdata[34], want.moved);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basic_steps();
    test_register_corners();
    test_random_traffic(8, 82);
    test_random_traffic(82, 8);
    test_output_stall();
    test_random_traffic(0, 0);
    wait_idle();
    repeat (8) @(negedge clk);
    $display("Run covered %0d samples (%0d failed reads) over %0d random register settings",
             sample_count, failed_count, setting_count);
    $display("Checked %0d results, %0d of them steps, with one long output stall",
             result_count, step_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS absolute_angle_to_step_tracker");
    end else begin
      $display("FAIL absolute_angle_to_step_tracker");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("FAIL absolute_angle_to_step_tracker");
    $finish;
  end

endmodule
